FILE: hdl/mfiw_pkg.sv
`timescale 1ns / 1ps

package mfiw_pkg;

    localparam int MAX_WINDOW  = 256;
    localparam int SLOT_W      = $clog2(MAX_WINDOW);
    localparam int WIN_W       = 9;
    localparam int PRICE_W     = 24;
    localparam int VOLUME_W    = 32;
    localparam int FLOW_W      = PRICE_W + VOLUME_W;
    localparam int SUM_W       = 64;
    localparam int TOTAL_W     = SUM_W + 1;
    localparam int Q_W         = 15;
    localparam int NUM_W       = SUM_W + Q_W;
    localparam int CNT_W       = $clog2(Q_W);
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 16;
    localparam int ADDR_W      = 3;

    localparam logic [WIN_W-1:0] RESET_WINDOW = WIN_W'(14);
    localparam logic [Q_W-1:0]   HALF_Q8      = Q_W'(12800);

    localparam logic [ADDR_W-1:0] REG_WINDOW_LENGTH = ADDR_W'(0);

    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [FLOW_W-1:0] t_flow;
    typedef logic [NUM_W-1:0]  t_num;

    typedef struct packed {
        logic  is_up;
        t_flow mag;
    } t_ring_entry;

endpackage

FILE: hdl/money_flow_index_window_core.sv
`timescale 1ns / 1ps

// channel   | direction | signals                 | contents
// ----------+-----------+-------------------------+------------------------------------
// s_axis    | in        | tvalid tready tdata     | price [23:0], volume [55:24]
// m_axis    | out       | tvalid tready tdata     | mfi_q8 [14:0]; tuser window_filled
// apb       | in        | psel penable pwrite ... | reg 0 at 0x0: window_length [8:0]
//
// an item passes from acceptance to a valid result through these steps: the flow ring
// read at acceptance, then multiply and removal of the oldest flow, then add and ring write-back,
// quotient set-up and 15 steps of the serial divider, then the output load.
// a new item is accepted once the previous one has been handed to the output register.
// synchronous active-low reset; no clearing pass, ring entries are read only after
// they were written. a stalled output holds its result and blocks the next load.

module money_flow_index_window_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mfiw_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // price, volume
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mfiw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // mfi_q8, zero pad
    output logic                             m_axis_tuser,  // window_filled
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mfiw_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import mfiw_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]          r_state;
    logic [WIN_W-1:0]    r_window;
    t_sum                r_up, r_down;
    logic [PRICE_W-1:0]  r_prev, r_price;
    logic [VOLUME_W-1:0] r_volume;
    logic [WIN_W-1:0]    r_fill;
    logic [SLOT_W-1:0]   r_slot, r_cur_slot;
    t_flow               r_flow;
    logic                r_is_up, r_moved;
    t_ring_entry         r_ring [MAX_WINDOW];
    t_ring_entry         r_rd_data;
    t_num                r_rem, r_div;
    logic [Q_W-1:0]      r_q;
    logic                r_zero;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    logic [Q_W-1:0]      r_out_q;
    logic                r_out_filled;

    logic [WIN_W-1:0]    eff_w;
    logic [SLOT_W-1:0]   acc_slot;
    logic [WIN_W-1:0]    next_slot;
    logic [PRICE_W-1:0]  base_price;
    logic                filled;
    logic                in_fire, cfg_wr, out_load;
    t_flow               add_mag;
    logic [TOTAL_W-1:0]  add_sum;
    t_sum                add_sat;
    t_num                num;
    logic [TOTAL_W-1:0]  total;

    assign pready = 1'b1;
    assign prdata = {{(32-WIN_W){1'b0}}, r_window};
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[ADDR_W-1:2] == REG_WINDOW_LENGTH[ADDR_W-1:2]);

    always_comb begin
        priority if (r_window == '0) begin
            eff_w = WIN_W'(1);
        end else if (r_window > WIN_W'(MAX_WINDOW)) begin
            eff_w = WIN_W'(MAX_WINDOW);
        end else begin
            eff_w = r_window;
        end
    end

    assign acc_slot   = ({1'b0, r_slot} >= eff_w) ? '0 : r_slot;
    assign next_slot  = {1'b0, r_cur_slot} + WIN_W'(1);
    assign base_price = (r_fill == '0) ? r_price : r_prev;
    assign filled     = (r_fill >= eff_w);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    assign add_mag = r_moved ? r_flow : '0;
    assign add_sum = {1'b0, (r_is_up ? r_up : r_down)} + TOTAL_W'(add_mag);
    assign add_sat = add_sum[SUM_W] ? '1 : add_sum[SUM_W-1:0];

    assign total = {1'b0, r_up} + {1'b0, r_down};
    assign num   = (NUM_W'(r_up) << 14) + (NUM_W'(r_up) << 13) + (NUM_W'(r_up) << 10);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-Q_W){1'b0}}, r_out_q};
    assign m_axis_tuser  = r_out_filled;

    // flow ring
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ADD) begin
            r_ring[r_cur_slot] <= '{is_up: r_is_up, mag: add_mag};
        end
        if (in_fire) begin
            r_rd_data <= r_ring[acc_slot];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_price    <= s_axis_tdata[PRICE_W-1:0];
            r_volume   <= s_axis_tdata[PRICE_W +: VOLUME_W];
            r_cur_slot <= acc_slot;
        end
        if (r_state == ST_MUL) begin
            r_flow  <= FLOW_W'(r_price) * FLOW_W'(r_volume);
            r_is_up <= (r_price > base_price);
            r_moved <= (r_price != base_price);
        end
        if (r_state == ST_PREP) begin
            r_zero <= (total == '0);
            r_rem  <= num;
            r_div  <= NUM_W'(total) << 14;
            r_q    <= '0;
        end
        if (r_state == ST_DIV) begin
            if (r_rem >= r_div) begin
                r_rem <= r_rem - r_div;
            end
            r_q   <= {r_q[Q_W-2:0], (r_rem >= r_div)};
            r_div <= r_div >> 1;
        end
        if (out_load) begin
            r_out_q      <= r_zero ? HALF_Q8 : r_q;
            r_out_filled <= filled;
        end
    end

    // control and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= RESET_WINDOW;
            r_up        <= '0;
            r_down      <= '0;
            r_prev      <= '0;
            r_fill      <= '0;
            r_slot      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                r_window <= pwdata[WIN_W-1:0];
                r_up     <= '0;
                r_down   <= '0;
                r_prev   <= '0;
                r_fill   <= '0;
                r_slot   <= '0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prev <= r_price;
                    if (filled) begin
                        if (r_rd_data.is_up) begin
                            r_up <= (r_up > SUM_W'(r_rd_data.mag)) ?
                                    r_up - SUM_W'(r_rd_data.mag) : '0;
                        end else begin
                            r_down <= (r_down > SUM_W'(r_rd_data.mag)) ?
                                      r_down - SUM_W'(r_rd_data.mag) : '0;
                        end
                    end else begin
                        r_fill <= r_fill + WIN_W'(1);
                    end
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    if (r_is_up) begin
                        r_up <= add_sat;
                    end else begin
                        r_down <= add_sat;
                    end
                    r_slot  <= (next_slot >= eff_w) ? '0 : next_slot[SLOT_W-1:0];
                    r_state <= ST_PREP;
                end
                ST_PREP: begin
                    r_cnt   <= CNT_W'(Q_W - 1);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: dv/tb_money_flow_index_window_core.sv
`timescale 1ns / 1ps

module tb_money_flow_index_window_core;
    import mfiw_pkg::*;

    localparam int Q8_SCALE       = 25600;
    localparam int PRICE_MAX      = (1 << PRICE_W) - 1;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT        = 1700;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_PHASES     = 10;
    localparam logic [ADDR_W-1:0] REG_UNUSED = ADDR_W'(4);

    typedef struct packed {
        logic [Q_W-1:0] mfi;
        logic           filled;
    } t_mfi_result;

    class mfi_tracker;
        t_flow          flow_mag [MAX_WINDOW];
        bit             flow_rising [MAX_WINDOW];
        t_sum           rising_total;
        t_sum           falling_total;
        logic [PRICE_W-1:0] prior_price;
        int unsigned    samples_held;
        int unsigned    next_slot;
        logic [WIN_W-1:0] window_reg;
        t_mfi_result    pending [$];

        function new();
            window_reg = RESET_WINDOW;
            clear();
        endfunction

        function void clear();
            rising_total = '0;
            falling_total = '0;
            prior_price = '0;
            samples_held = 0;
            next_slot = 0;
        endfunction

        function void set_window(logic [WIN_W-1:0] value);
            window_reg = value;
            clear();
        endfunction

        function t_sum add_clamped(t_sum a, t_flow b);
            logic [SUM_W:0] s;
            s = {1'b0, a} + (SUM_W + 1)'(b);
            return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
        endfunction

        function void note_sample(logic [PRICE_W-1:0] price, logic [VOLUME_W-1:0] volume);
            int unsigned span;
            int unsigned slot;
            t_flow       flow;
            bit          rising;
            t_num        numer;
            t_num        denom;
            t_mfi_result r;
            span = (window_reg == 0) ? 1 : ((window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg);
            slot = (next_slot >= span) ? 0 : next_slot;
            if (samples_held == 0) prior_price = price;
            rising = price > prior_price;
            flow = (price == prior_price) ? '0 : t_flow'(price) * t_flow'(volume);
            prior_price = price;
            // oldest flow leaves the window once it is full
            if (samples_held >= span) begin
                if (flow_rising[slot]) begin
                    rising_total = (rising_total > flow_mag[slot]) ?
                                   rising_total - flow_mag[slot] : '0;
                end else begin
                    falling_total = (falling_total > flow_mag[slot]) ?
                                    falling_total - flow_mag[slot] : '0;
                end
            end else begin
                samples_held++;
            end
            if (rising) rising_total = add_clamped(rising_total, flow);
            else falling_total = add_clamped(falling_total, flow);
            flow_mag[slot] = flow;
            flow_rising[slot] = rising;
            next_slot = (slot + 1 >= span) ? 0 : slot + 1;
            if (rising_total == 0 && falling_total == 0) begin
                r.mfi = HALF_Q8;
            end else begin
                numer = t_num'(rising_total) * t_num'(Q8_SCALE);
                denom = t_num'(rising_total) + t_num'(falling_total);
                r.mfi = Q_W'(numer / denom);
            end
            r.filled = samples_held >= span;
            pending.push_back(r);
        endfunction

        function string check_result(logic [OUT_DATA_W-1:0] data, logic filled);
            t_mfi_result want;
            if (pending.size() == 0)
                return $sformatf("item mfi_q8 %0d filled %0b with nothing predicted",
                                 data, filled);
            want = pending.pop_front();
            if (data !== OUT_DATA_W'(want.mfi) || filled !== want.filled)
                return $sformatf("mfi_q8 %0d filled %0b, predicted mfi_q8 %0d filled %0b",
                                 data, filled, want.mfi, want.filled);
            return "";
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_W-1:0]     s_axis_tdata = '0;   // price [23:0], volume [55:24]
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]    m_axis_tdata;        // mfi_q8 [14:0], zero [15]
    logic                     m_axis_tuser;        // window_filled
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    mfi_tracker  tracker = new();
    int unsigned mismatches = 0;
    int unsigned sent_count = 0;
    int unsigned accepted_in = 0;
    int unsigned results_checked = 0;
    int unsigned window_writes = 0;
    int unsigned send_idle = 12;
    int unsigned recv_idle = 56;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned stuck_cycles = 0;
    string       verdict;

    money_flow_index_window_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // sample handshakes on the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                tracker.note_sample(s_axis_tdata[PRICE_W-1:0],
                                    s_axis_tdata[PRICE_W+VOLUME_W-1:PRICE_W]);
                accepted_in <= accepted_in + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                verdict = tracker.check_result(m_axis_tdata, m_axis_tuser);
                if (verdict != "") report_mismatch(verdict);
                results_checked <= results_checked + 1;
            end
        end
    end

    // output side, with one long hold-off to back up the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_in >= HOLD_AT) begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_sample(input logic [PRICE_W-1:0] price,
                               input logic [VOLUME_W-1:0] volume);
        if (sent_count < 700) begin
            send_idle = 12;
            recv_idle = 56;
        end else if (sent_count < 1400) begin
            send_idle = 56;
            recv_idle = 12;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {volume, price};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_checked != sent_count) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == REG_WINDOW_LENGTH) begin
            tracker.set_window(data[WIN_W-1:0]);
            window_writes++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_window();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= REG_WINDOW_LENGTH;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {{(32 - WIN_W){1'b0}}, tracker.window_reg})
            report_mismatch($sformatf("window_length read %0d, written %0d",
                                      prdata, tracker.window_reg));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [PRICE_W-1:0]  dir_price [24];
        logic [VOLUME_W-1:0] dir_vol [24];
        logic [31:0]         phase_cfg [NUM_PHASES];
        int unsigned         phase_len [NUM_PHASES];
        logic [PRICE_W-1:0]  price;
        logic [VOLUME_W-1:0] volume;
        int                  walk;
        int unsigned         roll;

        dir_price = '{24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000001, 24'hFFFFFF, 24'hFFFFFE,
                      24'hFFFFFE, 24'd5, 24'd6, 24'd6, 24'd4, 24'h800000,
                      24'h7FFFFF, 24'hAAAAAA, 24'h555555, 24'd100, 24'd100, 24'd101,
                      24'd99, 24'd200, 24'd150, 24'hFFFFFF, 24'h000000, 24'h000001};
        dir_vol = '{32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                    32'd1, 32'd1234, 32'd0, 32'd7, 32'hFFFFFFFF, 32'h55555555,
                    32'hAAAAAAAA, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1, 32'd1, 32'd1000,
                    32'd1000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0};
        phase_cfg = '{32'd1, 32'd0, 32'd2, 32'd3, 32'd256, 32'hFFFFFFFF, 32'd14, 32'd5,
                      32'd0, 32'd0};
        phase_len = '{120, 100, 150, 150, 400, 300, 200, 150, 200, 250};
        phase_cfg[8] = $urandom_range(64, 1);
        phase_cfg[9] = 32'hFFFFFE00 | $urandom_range(511, 0);
        price = '0;

        while (!i_rst_n) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        apb_read_window();

        // reset window, field extremes, first sample, flat, rising and falling prices
        for (int i = 0; i < 24; i++) send_sample(dir_price[i], dir_vol[i]);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            apb_write(REG_WINDOW_LENGTH, phase_cfg[ph]);
            apb_read_window();
            for (int i = 0; i < phase_len[ph]; i++) begin
                // a write to an unmapped address must leave the window running
                if (ph == 3 && i == phase_len[ph] / 2) begin
                    settle();
                    apb_write(REG_UNUSED, 32'h1);
                    apb_read_window();
                end
                roll = $urandom_range(99);
                if (roll < 55) begin
                    walk = int'(price) + int'($urandom_range(2000)) - 1000;
                    if (walk < 0) walk = 0;
                    if (walk > PRICE_MAX) walk = PRICE_MAX;
                    price = PRICE_W'(walk);
                end else if (roll < 85) begin
                    if (roll >= 70) price = PRICE_W'($urandom);
                end else begin
                    price = $urandom_range(1) ? PRICE_W'(PRICE_MAX) : '0;
                end
                roll = $urandom_range(99);
                if (roll < 8) volume = '0;
                else if (roll < 16) volume = '1;
                else if (roll < 40) volume = VOLUME_W'($urandom_range(1000));
                else volume = $urandom;
                send_sample(price, volume);
            end
        end

        settle();
        if (tracker.pending.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      tracker.pending.size()));
        $display("sent %0d price/volume items, checked %0d index results", sent_count,
                 results_checked);
        $display("window settings applied: %0d, including 0, 1, 256 and above 256",
                 window_writes);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
